[rtl/mar_pkg.sv]
// mar_pkg: shared types, codes and constants of the matrix axis rotation block.
// Holds the transfer structs, the kind codes, the sequencer states and the CORDIC angle table.
// No dependencies.
package mar_pkg;

	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int ELEMENT_COUNT_DEF = 16;
	localparam int ATAN_LEN          = 24;
	localparam int IDX_W             = 4;
	localparam int COEF_W            = 18;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	typedef enum logic [2:0] {
		KIND_IDENT = 3'd0,
		KIND_LOAD  = 3'd1,
		KIND_ROT_X = 3'd2,
		KIND_ROT_Y = 3'd3,
		KIND_ROT_Z = 3'd4,
		KIND_READ  = 3'd5
	} kind_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         elem_index;
		logic signed [31:0] elem_value;
		logic [15:0]        turn_angle;
	} item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               overflow;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OP,
		ST_CORD,
		ST_RA,
		ST_RB,
		ST_LB,
		ST_MB,
		ST_W1,
		ST_WA,
		ST_WB,
		ST_FIN_RD,
		ST_FIN_OUT
	} state_t;

	// atan(2^-i) in 2^32-per-turn units
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] ident_val(input logic [IDX_W-1:0] idx);
		return (idx[1:0] == idx[3:2]) ? ONE_Q16 : 32'sd0;
	endfunction

endpackage

[rtl/matrix_axis_rotation.sv]
// matrix_axis_rotation: 4x4 Q16.16 matrix with identity, load, read and axis rotations.
// Top level: sequencer around mar_store, mar_cordic and mar_mac; depends on mar_pkg.
//
// Usage:
//   An item transfers on a rising edge with start high and busy low. busy stays
//   high until the item's single result is on result, marked by done for exactly
//   one cycle; the receiver cannot hold it off, so it must take it then.
//   Identity, load, read and unused kinds: the sequencer passes through the op
//   and read-back states, and done is registered from the last of them.
//   Rotations: the CORDIC iterates CORDIC_STEPS micro-rotations, then each of
//   the four rows takes two reads, two passes through the three-stage
//   multiply-accumulate and two write-backs, then a read-back raises done.
//   A new item may transfer in the cycle that done is high.
//   The single read port and single write port of the element memory and the
//   shared multiply-accumulate set the row schedule.
//   Reset returns the matrix to the identity at once (valid bits cleared) and
//   leaves the block idle; no result is pending after reset.
module matrix_axis_rotation import mar_pkg::*; #(
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
	parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	state_t state_q, state_d;

	item_t              item_q;
	logic [1:0]         row_q;
	logic signed [31:0] a_q, b_q;
	logic               ovf_q;
	result_t            result_q;
	logic               done_q;

	logic                     accept;
	logic                     is_rot;
	logic                     cord_fin;
	logic signed [COEF_W-1:0] cos_val, sin_val;
	logic signed [COEF_W-1:0] k1, k2;
	logic [1:0]               col_a, col_b;
	logic [IDX_W-1:0]         addr_a, addr_b;

	logic                     clr;
	logic [IDX_W-1:0]         rd_addr, wr_addr;
	logic                     wr_en;
	logic signed [31:0]       wr_data, rd_data;
	logic signed [31:0]       mx0, mx1, my;
	logic signed [COEF_W-1:0] mk0, mk1;
	logic                     msat;

	assign accept = start && !busy;
	assign is_rot = (item.kind == KIND_ROT_X) || (item.kind == KIND_ROT_Y)
		|| (item.kind == KIND_ROT_Z);

	mar_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept && is_rot),
		.angle   (item.turn_angle),
		.fin     (cord_fin),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	mar_store #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	mar_mac u_mac (
		.clk (clk),
		.x0  (mx0),
		.k0  (mk0),
		.x1  (mx1),
		.k1  (mk1),
		.y   (my),
		.sat (msat)
	);

	// column pair and cross coefficients per rotation mode
	always_comb begin
		case (item_q.kind)
			KIND_ROT_X: begin
				col_a = 2'd0;
				col_b = 2'd2;
				k1    = -sin_val;
			end
			KIND_ROT_Y: begin
				col_a = 2'd1;
				col_b = 2'd2;
				k1    = sin_val;
			end
			default: begin
				col_a = 2'd0;
				col_b = 2'd1;
				k1    = sin_val;
			end
		endcase
		k2     = -k1;
		addr_a = {row_q, col_a};
		addr_b = {row_q, col_b};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept) state_d = is_rot ? ST_CORD : ST_OP;
			ST_OP:      state_d = ST_FIN_RD;
			ST_CORD:    if (cord_fin) state_d = ST_RA;
			ST_RA:      state_d = ST_RB;
			ST_RB:      state_d = ST_LB;
			ST_LB:      state_d = ST_MB;
			ST_MB:      state_d = ST_W1;
			ST_W1:      state_d = ST_WA;
			ST_WA:      state_d = ST_WB;
			ST_WB:      state_d = (row_q == 2'd3) ? ST_FIN_RD : ST_RA;
			ST_FIN_RD:  state_d = ST_FIN_OUT;
			ST_FIN_OUT: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		clr     = 1'b0;
		rd_addr = item_q.elem_index;
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = my;
		mx0     = a_q;
		mk0     = cos_val;
		mx1     = rd_data;
		mk1     = k1;
		unique case (state_q)
			ST_OP: begin
				clr     = (item_q.kind == KIND_IDENT);
				wr_en   = (item_q.kind == KIND_LOAD);
				wr_addr = item_q.elem_index;
				wr_data = item_q.elem_value;
			end
			ST_RA: rd_addr = addr_a;
			ST_RB: rd_addr = addr_b;
			ST_MB: begin
				mk0 = k2;
				mx1 = b_q;
				mk1 = cos_val;
			end
			ST_WA: wr_en = 1'b1;
			ST_WB: begin
				wr_en   = 1'b1;
				wr_addr = addr_b;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			row_q   <= 2'd0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN_OUT);
			if (accept) begin
				row_q <= 2'd0;
				ovf_q <= 1'b0;
			end else if (state_q == ST_WA) begin
				ovf_q <= ovf_q | msat;
			end else if (state_q == ST_WB) begin
				ovf_q <= ovf_q | msat;
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= item;
		if (state_q == ST_RB)
			a_q <= rd_data;
		if (state_q == ST_LB)
			b_q <= rd_data;
		if (state_q == ST_FIN_OUT) begin
			result_q.read_value <= rd_data;
			result_q.overflow   <= ovf_q;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/mar_cordic.sv]
// mar_cordic: iterative CORDIC giving cosine and sine (Q4.14) of a 16-bit turn angle.
// One micro-rotation per cycle with quadrant folding; depends on mar_pkg.
module mar_cordic import mar_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [15:0]              angle,
	output logic                     fin,
	output logic signed [COEF_W-1:0] cos_val,
	output logic signed [COEF_W-1:0] sin_val
);

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	logic              run_q;
	logic              fin_q;
	logic [STEP_W-1:0] it_q;
	logic [1:0]        quad_q;
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;

	logic [15:0]        ang_bias;
	logic [1:0]         quad;
	logic [15:0]        resid;
	logic signed [33:0] dx, dy;
	logic signed [32:0] dz;
	logic signed [34:0] xr, yr;
	logic signed [COEF_W-1:0] cc, ss;

	always_comb begin
		ang_bias = angle + 16'h2000;
		quad     = ang_bias[15:14];
		resid    = angle - {quad, 14'd0};
		dx       = y_q >>> it_q;
		dy       = x_q >>> it_q;
		dz       = {3'd0, atan_turn(5'(it_q))};
		xr       = {x_q[33], x_q} + 35'sd32768;
		yr       = {y_q[33], y_q} + 35'sd32768;
		cc       = xr[COEF_W+15:16];
		ss       = yr[COEF_W+15:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			it_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				it_q  <= '0;
			end else if (run_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quad_q <= quad;
			x_q    <= CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= {resid[15], resid, 16'd0};
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - dz;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + dz;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = cc;
				sin_val = ss;
			end
			2'd1: begin
				cos_val = -ss;
				sin_val = cc;
			end
			2'd2: begin
				cos_val = -cc;
				sin_val = -ss;
			end
			default: begin
				cos_val = ss;
				sin_val = -cc;
			end
		endcase
	end

	assign fin = fin_q;

endmodule

[rtl/mar_mac.sv]
// mar_mac: pipelined sum of two Q16.16 x Q4.14 products, rounded and saturated to 32 bits.
// Three register stages: products, sum, round/saturate; depends on mar_pkg.
module mar_mac import mar_pkg::*; (
	input  logic                     clk,
	input  logic signed [31:0]       x0,
	input  logic signed [COEF_W-1:0] k0,
	input  logic signed [31:0]       x1,
	input  logic signed [COEF_W-1:0] k1,
	output logic signed [31:0]       y,
	output logic                     sat
);

	logic signed [31+COEF_W:0] p0_s1, p1_s1;
	logic signed [32+COEF_W:0] sum_s2;
	logic signed [31:0]        y_s3;
	logic                      sat_s3;

	logic signed [32+COEF_W:0] rnd;
	logic signed [18+COEF_W:0] shr;
	logic                      hi, lo;

	always_comb begin
		rnd = sum_s2 + (32+COEF_W+1)'(8192);
		shr = rnd[32+COEF_W:14];
		hi  = !shr[18+COEF_W] && (shr[17+COEF_W:31] != '0);
		lo  = shr[18+COEF_W] && (shr[17+COEF_W:31] != '1);
	end

	always_ff @(posedge clk) begin
		p0_s1  <= x0 * k0;
		p1_s1  <= x1 * k1;
		sum_s2 <= {p0_s1[31+COEF_W], p0_s1} + {p1_s1[31+COEF_W], p1_s1};
		sat_s3 <= hi || lo;
		if (hi)
			y_s3 <= 32'sh7FFF_FFFF;
		else if (lo)
			y_s3 <= 32'sh8000_0000;
		else
			y_s3 <= shr[31:0];
	end

	assign y   = y_s3;
	assign sat = sat_s3;

endmodule

[rtl/mar_store.sv]
// mar_store: matrix element memory, one write and one registered read per cycle.
// Per-entry valid bits; an entry not valid reads as the identity value. Depends on mar_pkg.
module mar_store import mar_pkg::*; #(
	parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clr,
	input  logic [$clog2(ELEMENT_COUNT)-1:0] rd_addr,
	input  logic                             wr_en,
	input  logic [$clog2(ELEMENT_COUNT)-1:0] wr_addr,
	input  logic signed [31:0]               wr_data,
	output logic signed [31:0]               rd_data
);

	localparam int AW = $clog2(ELEMENT_COUNT);

	logic signed [31:0]       mem [ELEMENT_COUNT];
	logic [ELEMENT_COUNT-1:0] vld_q;
	logic signed [31:0]       rd_q;
	logic                     rd_vld_q;
	logic [AW-1:0]            rd_addr_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q      <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clr)
				vld_q <= '0;
			else if (wr_en)
				vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_q ? rd_q : ident_val(IDX_W'(rd_addr_q));

endmodule

[rtl/mar_chk.sv]
// mar_chk: port-level checks of the matrix axis rotation block, bound to the top level.
// Watches the start/busy/done sequence and that the overflow flag is known on a result; depends on mar_pkg.
module mar_chk import mar_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a transfer");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

	a_ovf_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result.overflow) && !$isunknown(item.kind) || !done)
		else $error("overflow flag unknown on result");

endmodule

bind matrix_axis_rotation mar_chk u_mar_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

[verif/mar_result_checker.sv]
// mar_result_checker: watches the command and result channels of matrix_axis_rotation.
// Keeps a shadow copy of the matrix, predicts every result and compares it field by field.
// Depends on mar_pkg.
module mar_result_checker import mar_pkg::*; #(
	parameter int ROT_STEPS = CORDIC_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    done,
	input  result_t result,
	output int      errors,
	output int      outstanding,
	output int      compared,
	output int      saturated
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_HI    = 64'sd2147483647;
	localparam longint SAT_LO    = -64'sd2147483648;
	localparam longint GAIN_Q30  = 64'sd652032874;
	localparam int     ATAN_ROWS = 24;

	// atan(2^-i), 2^32 units per turn
	longint atan_tab [0:ATAN_ROWS-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	int      shadow_mat [0:15];
	result_t pending_results [$];

	function automatic void load_identity();
		int k;
		for (k = 0; k < 16; k++)
			shadow_mat[k] = ((k & 3) == (k >> 2)) ? 65536 : 0;
	endfunction

	function automatic void angle_trig(input logic [15:0] ang, output longint c,
			output longint s);
		logic [15:0] biased;
		logic [15:0] resid;
		logic [1:0]  quad;
		longint      x, y, z, dx, dy, cc, ss;
		int          i;
		biased = ang + 16'h2000;
		quad   = biased[15:14];
		resid  = ang - {quad, 14'd0};
		x = GAIN_Q30;
		y = 0;
		z = longint'($signed(resid)) * 65536;
		for (i = 0; i < ROT_STEPS && i < ATAN_ROWS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_tab[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_tab[i];
			end
		end
		cc = (x + 32768) >>> 16;
		ss = (y + 32768) >>> 16;
		case (quad)
			2'd0: begin
				c = cc;
				s = ss;
			end
			2'd1: begin
				c = -ss;
				s = cc;
			end
			2'd2: begin
				c = -cc;
				s = -ss;
			end
			default: begin
				c = ss;
				s = -cc;
			end
		endcase
	endfunction

	function automatic int round_sat(input longint acc, inout logic sat);
		longint v;
		v = (acc + 8192) >>> 14;
		if (v > SAT_HI) begin
			sat = 1'b1;
			v = SAT_HI;
		end else if (v < SAT_LO) begin
			sat = 1'b1;
			v = SAT_LO;
		end
		return int'(v);
	endfunction

	function automatic result_t predict_op(input item_t it);
		result_t r;
		logic    sat;
		longint  c, s, m0, m1, m2;
		int      row, b;
		sat = 1'b0;
		case (it.kind)
			KIND_IDENT: load_identity();
			KIND_LOAD: shadow_mat[it.elem_index] = it.elem_value;
			KIND_ROT_X, KIND_ROT_Y, KIND_ROT_Z: begin
				angle_trig(it.turn_angle, c, s);
				for (row = 0; row < 4; row++) begin
					b  = row * 4;
					m0 = shadow_mat[b];
					m1 = shadow_mat[b + 1];
					m2 = shadow_mat[b + 2];
					if (it.kind == KIND_ROT_X) begin
						shadow_mat[b]     = round_sat(m0 * c - m2 * s, sat);
						shadow_mat[b + 2] = round_sat(m0 * s + m2 * c, sat);
					end else if (it.kind == KIND_ROT_Y) begin
						shadow_mat[b + 1] = round_sat(m1 * c + m2 * s, sat);
						shadow_mat[b + 2] = round_sat(-m1 * s + m2 * c, sat);
					end else begin
						shadow_mat[b]     = round_sat(m0 * c + m1 * s, sat);
						shadow_mat[b + 1] = round_sat(-m0 * s + m1 * c, sat);
					end
				end
			end
			default: ;
		endcase
		r.read_value = shadow_mat[it.elem_index];
		r.overflow   = sat;
		return r;
	endfunction

	task automatic note_fault(input string what, input longint exp_v, input longint got_v);
		if (errors < 10)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			load_identity();
			pending_results.delete();
			errors      = 0;
			outstanding = 0;
			compared    = 0;
			saturated   = 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					note_fault("unrequested result", 0, result.read_value);
				end else begin
					want = pending_results.pop_front();
					compared++;
					if (result.overflow === 1'b1)
						saturated++;
					if (result.read_value !== want.read_value)
						note_fault("read_value", want.read_value, result.read_value);
					if (result.overflow !== want.overflow)
						note_fault("overflow", want.overflow, result.overflow);
				end
			end
			if (start && !busy)
				pending_results.push_back(predict_op(item));
			outstanding = pending_results.size();
		end
	end

endmodule

[verif/matrix_axis_rotation_tb.sv]
// matrix_axis_rotation_tb: stimulus and verdict for matrix_axis_rotation.
// Directed corner items, then weighted random operations with random gaps;
// results are checked by mar_result_checker. Depends on mar_pkg.
module matrix_axis_rotation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mar_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam int         ITEM_TARGET  = 1350;
	localparam int         DRAIN_EVERY  = 300;
	localparam int         TAIL_CYCLES  = 64;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    done;
	item_t   item;
	result_t result;

	int errors, outstanding, compared, saturated;
	int issued;
	int flat_run;
	int op_tally [0:7];

	logic signed [31:0] corner_vals [0:5] = '{
		32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, -32'sd1, 32'sd65536, -32'sd65536
	};
	logic [15:0] corner_angles [0:9] = '{
		16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
		16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF
	};

	matrix_axis_rotation uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	mar_result_checker #(.ROT_STEPS(CORDIC_STEPS_DEF)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding),
		.compared    (compared),
		.saturated   (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic item_t mk_item(input logic [2:0] k, input logic [3:0] idx,
			input logic signed [31:0] val, input logic [15:0] ang);
		item_t it;
		it.kind       = k;
		it.elem_index = idx;
		it.elem_value = val;
		it.turn_angle = ang;
		return it;
	endfunction

	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0: v = corner_vals[$urandom_range(0, 5)];
			1, 2: v = $urandom;
			default: v = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_angle();
		logic [15:0] a;
		if ($urandom_range(0, 9) < 3)
			a = corner_angles[$urandom_range(0, 9)] + 16'($urandom_range(0, 2)) - 16'd1;
		else
			a = $urandom_range(0, 65535);
		return a;
	endfunction

	task automatic issue(input item_t it);
		int gap;
		if (flat_run > 0) begin
			gap = 0;
			flat_run--;
		end else begin
			gap = $urandom_range(0, 4);
			if ($urandom_range(0, 39) == 0)
				flat_run = $urandom_range(20, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		op_tally[it.kind]++;
		issued++;
	endtask

	// hold off until every result in flight has come back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		item_t it;
		int    pick, k, next_drain;
		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		issued   = 0;
		flat_run = 0;
		for (k = 0; k < 8; k++)
			op_tally[k] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		issue(mk_item(KIND_READ,  4'd0,  32'sd0, 16'h0000));
		issue(mk_item(KIND_READ,  4'd15, 32'sd0, 16'h0000));
		issue(mk_item(KIND_LOAD,  4'd0,  32'sh7FFFFFFF, 16'h0000));
		issue(mk_item(KIND_LOAD,  4'd2,  32'sh7FFFFFFF, 16'h0000));
		issue(mk_item(KIND_ROT_X, 4'd2,  32'sd0, 16'h2000));
		issue(mk_item(KIND_LOAD,  4'd8,  32'sh80000000, 16'h0000));
		issue(mk_item(KIND_LOAD,  4'd10, 32'sh80000000, 16'h0000));
		issue(mk_item(KIND_ROT_X, 4'd8,  32'sd0, 16'hE000));
		issue(mk_item(KIND_IDENT, 4'd5,  32'sd0, 16'h0000));
		issue(mk_item(KIND_ROT_X, 4'd0,  32'sd0, 16'h0000));
		issue(mk_item(KIND_ROT_Y, 4'd6,  32'sd0, 16'h4000));
		issue(mk_item(KIND_ROT_Z, 4'd1,  32'sd0, 16'h8000));
		issue(mk_item(KIND_ROT_Z, 4'd4,  32'sd0, 16'hC000));
		issue(mk_item(KIND_ROT_Y, 4'd9,  32'sd0, 16'h1FFF));
		issue(mk_item(KIND_ROT_X, 4'd2,  32'sd0, 16'h6000));
		issue(mk_item(KIND_ROT_Z, 4'd0,  32'sd0, 16'hFFFF));
		issue(mk_item(KIND_LOAD,  4'd15, -32'sd1, 16'hFFFF));
		issue(mk_item(KIND_LOAD,  4'd7,  32'sd0, 16'h0000));
		issue(mk_item(KIND_SPARE_A, 4'd15, 32'sh7FFFFFFF, 16'hFFFF));
		issue(mk_item(KIND_SPARE_B, 4'd3, 32'sh80000000, 16'h8000));
		issue(mk_item(KIND_LOAD,  4'd5,  32'sh80000000, 16'h0000));
		issue(mk_item(KIND_ROT_Y, 4'd5,  32'sd0, 16'hA000));
		issue(mk_item(KIND_READ,  4'd5,  32'sd0, 16'h0000));
		issue(mk_item(KIND_IDENT, 4'd15, 32'sd0, 16'h0000));
		drain();

		next_drain = issued + DRAIN_EVERY;
		while (issued < ITEM_TARGET) begin
			it = mk_item(KIND_READ, 4'($urandom_range(0, 15)), $urandom,
				16'($urandom_range(0, 65535)));
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// fill the whole matrix so that rotations act on dense rows
				for (k = 0; k < 16; k++)
					issue(mk_item(KIND_LOAD, 4'(k), pick_value(), 16'($urandom)));
			end else begin
				if (pick < 9)
					it.kind = KIND_IDENT;
				else if (pick < 33) begin
					it.kind       = KIND_LOAD;
					it.elem_value = pick_value();
				end else if (pick < 45)
					it.kind = KIND_READ;
				else if (pick < 49)
					it.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
				else begin
					it.kind       = 3'(KIND_ROT_X) + 3'($urandom_range(0, 2));
					it.turn_angle = pick_angle();
				end
				issue(it);
			end
			if (issued >= next_drain) begin
				drain();
				next_drain = issued + DRAIN_EVERY;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d transfers: %0d identity, %0d load, %0d read, %0d unused kind;",
			issued, op_tally[KIND_IDENT], op_tally[KIND_LOAD], op_tally[KIND_READ],
			op_tally[KIND_SPARE_A] + op_tally[KIND_SPARE_B]);
		$display("rotations x/y/z %0d/%0d/%0d, %0d results compared, %0d saturating.",
			op_tally[KIND_ROT_X], op_tally[KIND_ROT_Y], op_tally[KIND_ROT_Z],
			compared, saturated);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
